FILE: sv/fpa_pkg.sv
package fpa_pkg;

	localparam int unsigned FRAC_BITS = 8;
	localparam int unsigned DIV_STAGES = 34;

	localparam logic [63:0] HALF_LSB = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
	localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] RAW_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		FN_ADD = 3'd0,
		FN_SUB = 3'd1,
		FN_MUL = 3'd2,
		FN_DIV = 3'd3,
		FN_MIN = 3'd4,
		FN_MAX = 3'd5,
		FN_INC = 3'd6,
		FN_DEC = 3'd7
	} func_t;

	typedef struct packed {
		logic [31:0] res;
		logic        ovf;
	} sat_t;

	typedef struct packed {
		func_t              func;
		logic               gt;
		logic               lt;
		logic               eq;
		logic [31:0]        simple_res;
		logic               simple_ovf;
		logic signed [63:0] prod;
		logic               div_neg;
		logic               dz;
		logic [63:0]        rem;
		logic [32:0]        den;
		logic [32:0]        quo;
		logic               big;
	} item_t;

	function automatic sat_t clamp33(input logic [32:0] v);
		sat_t s;
		s.ovf = v[32] != v[31];
		s.res = s.ovf ? (v[32] ? RAW_MIN : RAW_MAX) : v[31:0];
		return s;
	endfunction

	function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
		sat_t s;
		if (neg) begin
			s.ovf = mag > 64'h0000_0000_8000_0000;
			s.res = s.ovf ? RAW_MIN : (~mag[31:0] + 32'd1);
		end else begin
			s.ovf = mag > 64'h0000_0000_7FFF_FFFF;
			s.res = s.ovf ? RAW_MAX : mag[31:0];
		end
		return s;
	endfunction

endpackage

FILE: sv/fpa_div_pipe.sv
module fpa_div_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  fpa_pkg::item_t in_item,
	output logic           out_vld,
	output fpa_pkg::item_t out_item
);
	import fpa_pkg::*;

	item_t stg_s [DIV_STAGES];
	logic  vld_s [DIV_STAGES];
	item_t nxt   [DIV_STAGES];

	always_comb begin
		item_t       src;
		logic [65:0] dsh;
		logic        ge;
		for (int j = 0; j < int'(DIV_STAGES); j++) begin
			src = (j == 0) ? in_item : stg_s[j - 1];
			dsh = {33'd0, src.den} << (DIV_STAGES - 1 - j);
			ge  = {2'b00, src.rem} >= dsh;
			nxt[j] = src;
			if (j == 0) begin
				nxt[j].big = ge;
			end else if (ge) begin
				nxt[j].rem = src.rem - dsh[63:0];
				nxt[j].quo[DIV_STAGES - 1 - j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < int'(DIV_STAGES); j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < int'(DIV_STAGES); j++)
				vld_s[j] <= (j == 0) ? in_vld : vld_s[j - 1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < int'(DIV_STAGES); j++) stg_s[j] <= nxt[j];
		end
	end

	assign out_vld  = vld_s[DIV_STAGES - 1];
	assign out_item = stg_s[DIV_STAGES - 1];

endmodule

FILE: sv/fixed_point_alu.sv
// channel | dir | word
// s_*     | in  | tdata: operand_a[31:0], operand_b[63:32]; tuser: func[2:0]
// m_*     | out | tdata: result[31:0]; tuser: a_greater, a_less, a_equal, overflow,
//         |     |        divide_by_zero (bit 0 up)
// One word per cycle unless m_tready stalls; stages: operand stage, 34 divider stages, output stage.
// The pipeline depth is set by the restoring divider, one quotient bit per stage.
// Reset clears the valid bits only.
// A stall at m_tready freezes the whole pipeline; s_tready drops with it.
module fixed_point_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // operand_a, operand_b
	input  logic [2:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // result
	output logic [4:0]  m_tuser   // a_greater, a_less, a_equal, overflow, divide_by_zero
);
	import fpa_pkg::*;

	logic               en;
	logic signed [31:0] a, b;
	item_t              item_c, item_s1, item_p;
	logic               vld_s1, vld_p, vld_s3;
	logic [31:0]        res_s3;
	logic [4:0]         flg_s3;
	logic [31:0]        res_c;
	logic [4:0]         flg_c;

	assign en       = !vld_s3 || m_tready;
	assign s_tready = en;
	assign a        = s_tdata[31:0];
	assign b        = s_tdata[63:32];

	always_comb begin
		logic [31:0] mag_a, mag_b;
		logic [63:0] n;
		sat_t        s;
		mag_a = a[31] ? (~a + 32'd1) : a;
		mag_b = b[31] ? (~b + 32'd1) : b;
		n     = {32'd0, mag_a} << FRAC_BITS;
		item_c            = '0;
		item_c.func       = func_t'(s_tuser);
		item_c.gt         = a > b;
		item_c.lt         = a < b;
		item_c.eq         = a == b;
		item_c.prod       = a * b;
		item_c.div_neg    = a[31] != b[31];
		item_c.dz         = b == 32'sd0;
		item_c.rem        = {n[62:0], 1'b0} + {32'd0, mag_b};
		item_c.den        = {mag_b, 1'b0};
		s = '0;
		unique case (item_c.func)
			FN_ADD:  s = clamp33({a[31], a} + {b[31], b});
			FN_SUB:  s = clamp33({a[31], a} - {b[31], b});
			FN_MIN:  s.res = (a < b) ? a : b;
			FN_MAX:  s.res = (a > b) ? a : b;
			FN_INC:  s = clamp33({a[31], a} + 33'd1);
			FN_DEC:  s = clamp33({a[31], a} - 33'd1);
			default: s = '0;
		endcase
		item_c.simple_res = s.res;
		item_c.simple_ovf = s.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s3 <= vld_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) item_s1 <= item_c;
	end

	fpa_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.in_item  (item_s1),
		.out_vld  (vld_p),
		.out_item (item_p)
	);

	always_comb begin
		logic [63:0] mh;
		sat_t        s;
		mh = item_p.prod[63] ? (HALF_LSB - item_p.prod) : (item_p.prod + HALF_LSB);
		unique case (item_p.func)
			FN_MUL:  s = sat_mag(item_p.prod[63], mh >> FRAC_BITS);
			FN_DIV: begin
				if (item_p.dz) begin
					s.res = item_p.div_neg ^ item_p.den[0] ? RAW_MIN : RAW_MAX;
					s.ovf = 1'b0;
				end else begin
					s = sat_mag(item_p.div_neg, {30'd0, item_p.big, item_p.quo});
				end
			end
			default: begin
				s.res = item_p.simple_res;
				s.ovf = item_p.simple_ovf;
			end
		endcase
		if (item_p.func == FN_DIV && item_p.dz) begin
			s.res = item_p.lt ? RAW_MIN : RAW_MAX;
		end
		res_c = s.res;
		flg_c = {item_p.func == FN_DIV && item_p.dz, s.ovf, item_p.eq, item_p.lt, item_p.gt};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_c;
			flg_s3 <= flg_c;
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = res_s3;
	assign m_tuser  = flg_s3;

endmodule
